>>> sv/rectangle_overlap_occupancy_grid_top_macros.svh
// Assertion macros for the rectangle overlap occupancy grid.
`ifndef RECTANGLE_OVERLAP_OCCUPANCY_GRID_TOP_MACROS_SVH
`define RECTANGLE_OVERLAP_OCCUPANCY_GRID_TOP_MACROS_SVH

// Same-cycle implication.
`define ROOG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("roog assertion failed");

// Next-cycle implication.
`define ROOG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("roog assertion failed");

`endif

>>> sv/roog_pkg.sv
// Shared types and constants for the rectangle overlap occupancy grid.
package roog_pkg;

  localparam int GRID_SIDE_DEF = 1024;
  localparam int ID_BITS_DEF   = 16;

  localparam int CMD_W   = 1;
  localparam int OWNER_W = 16;
  localparam int EDGE_W  = 10;
  localparam int SIZE_W  = 11;
  localparam int CNT_W   = 21;

  localparam logic [CMD_W-1:0] CMD_ADD   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CHECK = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [OWNER_W-1:0] owner_id;
    logic [EDGE_W-1:0]  left_edge;
    logic [EDGE_W-1:0]  top_edge;
    logic [SIZE_W-1:0]  rect_width;
    logic [SIZE_W-1:0]  rect_height;
  } in_t;

  typedef struct packed {
    logic             intact;
    logic [CNT_W-1:0] overlap_cells;
    logic             clipped;
  } out_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic walk;
    logic clear;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic empty;
    logic walk_last;
  } status_t;

endpackage

>>> sv/roog_ram.sv
// Generic single-write, single-read RAM with registered read data.
module roog_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/roog_ctrl.sv
// Controller state machine: clearing pass, request intake, cell walk and result hand-off.
module roog_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  roog_pkg::status_t status,
  output roog_pkg::cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SETUP  = 6'b000100,
    S_WALK   = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = status.empty ? S_RESULT : S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/roog_dpath.sv
// Datapath: request latch, rectangle bounds, cell address walk, grid RAM and overlap count.
module roog_dpath #(
  parameter int GRID_SIDE = roog_pkg::GRID_SIDE_DEF,
  parameter int ID_BITS   = roog_pkg::ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  roog_pkg::in_t     in_data,
  input  roog_pkg::cmd_t    cmd,
  output roog_pkg::status_t status,
  output roog_pkg::out_t    out_data
);

  localparam int Depth = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = ($clog2(GRID_SIDE + 1) > 12) ? $clog2(GRID_SIDE + 1) : 12;
  localparam int ExtW  = (ID_BITS > roog_pkg::OWNER_W) ? ID_BITS : roog_pkg::OWNER_W;

  localparam logic [CW-1:0]      SideC   = CW'(GRID_SIDE);
  localparam logic [AW-1:0]      SideA   = AW'(GRID_SIDE);
  localparam logic [AW-1:0]      LastA   = AW'(Depth - 1);
  localparam logic [ID_BITS-1:0] MarkId  = '1;

  roog_pkg::in_t  req_r;
  roog_pkg::out_t out_r;

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_first_r, col_last_r, row_last_r;
  logic [AW-1:0] base_r, base_nxt;
  logic          clipped_r;
  logic          intact_r, intact_nxt;
  logic          pend_r;
  logic [AW-1:0] waddr_r;
  logic [AW-1:0] clr_addr_r;
  logic [roog_pkg::CNT_W-1:0] count_r, count_nxt;

  logic [ExtW-1:0]    id_ext;
  logic [ID_BITS-1:0] id_cut;
  logic [CW-1:0]      left_c, top_c, xe, ye, xe_cl, ye_cl;
  logic               has_area, clip_now, loop_empty;
  logic [AW-1:0]      rd_addr;
  logic [ID_BITS-1:0] rdata, new_val, wdata;
  logic [AW-1:0]      waddr;
  logic               we, bump, cell_we;

  assign id_ext = ExtW'(req_r.owner_id);
  assign id_cut = id_ext[ID_BITS-1:0];

  assign left_c     = CW'(req_r.left_edge);
  assign top_c      = CW'(req_r.top_edge);
  assign xe         = left_c + CW'(req_r.rect_width);
  assign ye         = top_c + CW'(req_r.rect_height);
  assign xe_cl      = (xe > SideC) ? SideC : xe;
  assign ye_cl      = (ye > SideC) ? SideC : ye;
  assign has_area   = (req_r.rect_width != '0) && (req_r.rect_height != '0);
  assign clip_now   = has_area && ((xe > SideC) || (ye > SideC));
  assign loop_empty = !has_area || (left_c >= xe_cl) || (top_c >= ye_cl);

  assign rd_addr = base_r + AW'(col_r);

  assign status.clr_last  = (clr_addr_r == LastA);
  assign status.empty     = loop_empty;
  assign status.walk_last = (col_r == col_last_r) && (row_r == row_last_r);

  assign new_val = (rdata != '0) ? MarkId : id_cut;
  assign bump    = ((rdata != '0) && (rdata != MarkId)) || ((rdata == '0) && (id_cut == MarkId));
  assign cell_we = pend_r && (req_r.command == roog_pkg::CMD_ADD);

  always_comb begin
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wdata = '0;
    end else begin
      we    = cell_we;
      waddr = waddr_r;
      wdata = new_val;
    end
  end

  roog_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (Depth),
    .AW    (AW)
  ) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    if (cmd.setup) begin
      col_nxt  = left_c;
      row_nxt  = top_c;
      base_nxt = AW'(AW'(req_r.top_edge) * SideA);
    end else if (cmd.walk) begin
      if (col_r == col_last_r) begin
        col_nxt  = col_first_r;
        row_nxt  = row_r + CW'(1);
        base_nxt = base_r + SideA;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_comb begin
    intact_nxt = intact_r;
    count_nxt  = count_r;
    if (cmd.setup) begin
      intact_nxt = 1'b1;
    end else if (pend_r) begin
      if (req_r.command == roog_pkg::CMD_CHECK) begin
        intact_nxt = intact_r && (rdata == id_cut);
      end else if (bump) begin
        count_nxt = count_r + roog_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      clr_addr_r <= '0;
      count_r    <= '0;
    end else begin
      pend_r  <= cmd.walk;
      count_r <= count_nxt;
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.setup) begin
      col_first_r <= left_c;
      col_last_r  <= xe_cl - CW'(1);
      row_last_r  <= ye_cl - CW'(1);
      clipped_r   <= clip_now;
    end
    col_r    <= col_nxt;
    row_r    <= row_nxt;
    base_r   <= base_nxt;
    intact_r <= intact_nxt;
    waddr_r  <= rd_addr;
    if (cmd.out_load) begin
      out_r.intact        <= (req_r.command == roog_pkg::CMD_CHECK) && intact_r &&
                             !(clipped_r && (id_cut != '0));
      out_r.overlap_cells <= count_r;
      out_r.clipped       <= clipped_r;
    end
  end

  assign out_data = out_r;

endmodule

>>> sv/rectangle_overlap_occupancy_grid_top.sv
// Top level of the rectangle overlap occupancy grid.
// After reset the grid RAM is swept to zero, one cell per cycle, across all of its
// GRID_SIDE*GRID_SIDE cells (1,048,576 at the default size) before in_ready rises. Each
// request then walks the in-grid part of its rectangle through the grid RAM's one read
// port and one write port at one cell per cycle, then a drain step and the result
// hand-off follow before the controller is ready again; with no cell of the rectangle in
// the grid, setup goes straight to the hand-off. One request is in flight at a time; its
// result sits in an output register while the next request is taken.
`include "rectangle_overlap_occupancy_grid_top_macros.svh"

module rectangle_overlap_occupancy_grid_top #(
  parameter int GRID_SIDE = roog_pkg::GRID_SIDE_DEF,
  parameter int ID_BITS   = roog_pkg::ID_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  roog_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output roog_pkg::out_t out_data
);

  roog_pkg::cmd_t    cmd;
  roog_pkg::status_t status;

  roog_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  roog_dpath #(
    .GRID_SIDE (GRID_SIDE),
    .ID_BITS   (ID_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  `ROOG_ASSERT_NOW(a_no_req_during_clear, cmd.clear, !in_ready)
  `ROOG_ASSERT_NOW(a_walk_excludes_clear, 1'b1, !(cmd.walk && cmd.clear))
  `ROOG_ASSERT_NEXT(a_one_req_in_flight, in_valid && in_ready, !in_ready)
  `ROOG_ASSERT_NEXT(a_result_presented, cmd.out_load, out_valid)

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the rectangle overlap occupancy grid top level.
module testbench;

  localparam int GRID = roog_pkg::GRID_SIDE_DEF;
  localparam int RUN_LIMIT = 12_000_000;
  localparam int CMD_W = roog_pkg::CMD_W;
  localparam int OWNER_W = roog_pkg::OWNER_W;
  localparam int EDGE_W = roog_pkg::EDGE_W;
  localparam int SIZE_W = roog_pkg::SIZE_W;
  localparam int CNT_W = roog_pkg::CNT_W;
  localparam logic [OWNER_W-1:0] OVERLAP_MARK = '1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  roog_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  roog_pkg::out_t out_data;

  bit [OWNER_W-1:0] grid_cells [GRID*GRID];
  int   overlap_count;
  roog_pkg::out_t pending_outcomes[$];
  roog_pkg::in_t  recent_adds[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int cycle_count;
  int mismatch_count;
  int requests_sent;
  int checks_sent;
  int intact_seen;
  int clipped_seen;

  rectangle_overlap_occupancy_grid_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count <= RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, pending_outcomes.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic roog_pkg::out_t apply_rectangle(roog_pkg::in_t req);
    roog_pkg::out_t res;
    int x_end;
    int y_end;
    int idx;
    logic [OWNER_W-1:0] prior;
    logic [OWNER_W-1:0] updated;
    logic clip;
    logic whole;
    x_end = int'(req.left_edge) + int'(req.rect_width);
    y_end = int'(req.top_edge) + int'(req.rect_height);
    clip = (req.rect_width != 0) && (req.rect_height != 0) && (x_end > GRID || y_end > GRID);
    // cells off the grid read as empty
    whole = !(clip && req.owner_id != 0);
    if (x_end > GRID) x_end = GRID;
    if (y_end > GRID) y_end = GRID;
    for (int y = int'(req.top_edge); y < y_end; y++) begin
      for (int x = int'(req.left_edge); x < x_end; x++) begin
        idx = y * GRID + x;
        prior = grid_cells[idx];
        if (req.command == roog_pkg::CMD_ADD) begin
          updated = (prior != 0) ? OVERLAP_MARK : req.owner_id;
          if (prior != OVERLAP_MARK && updated == OVERLAP_MARK) overlap_count++;
          grid_cells[idx] = updated;
        end else if (prior != req.owner_id) begin
          whole = 1'b0;
        end
      end
    end
    res.intact = (req.command == roog_pkg::CMD_CHECK) && whole;
    res.overlap_cells = overlap_count[CNT_W-1:0];
    res.clipped = clip;
    return res;
  endfunction

  function automatic roog_pkg::in_t make_random_request();
    roog_pkg::in_t req;
    int pick;
    int zone;
    int shape;
    req = '0;
    pick = $urandom_range(0, 99);
    if (pick < 40 && recent_adds.size() != 0) begin
      req = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
      req.command = roog_pkg::CMD_CHECK;
      if ($urandom_range(0, 3) == 0) begin
        req.rect_width = SIZE_W'($urandom_range(0, req.rect_width));
        req.rect_height = SIZE_W'($urandom_range(0, req.rect_height));
      end
      return req;
    end
    req.command = (pick < 50) ? roog_pkg::CMD_CHECK : roog_pkg::CMD_ADD;
    case ($urandom_range(0, 19))
      0: req.owner_id = '0;
      1: req.owner_id = '1;
      default: req.owner_id = OWNER_W'($urandom_range(1, 16'hFFFE));
    endcase
    zone = $urandom_range(0, 9);
    if (zone < 4) begin
      req.left_edge = EDGE_W'($urandom_range(0, 47));
      req.top_edge = EDGE_W'($urandom_range(0, 47));
    end else if (zone < 8) begin
      req.left_edge = EDGE_W'($urandom_range(0, GRID - 1));
      req.top_edge = EDGE_W'($urandom_range(0, GRID - 1));
    end else begin
      req.left_edge = EDGE_W'($urandom_range(GRID - 24, GRID - 1));
      req.top_edge = EDGE_W'($urandom_range(GRID - 24, GRID - 1));
    end
    shape = $urandom_range(0, 19);
    if (shape == 0) begin
      req.rect_width = SIZE_W'($urandom_range(0, 2047));
      req.rect_height = SIZE_W'($urandom_range(0, 1));
    end else if (shape == 1) begin
      req.rect_width = SIZE_W'($urandom_range(0, 1));
      req.rect_height = SIZE_W'($urandom_range(0, 2047));
    end else if (shape < 5) begin
      req.rect_width = SIZE_W'($urandom_range(0, 40));
      req.rect_height = SIZE_W'($urandom_range(0, 40));
    end else begin
      req.rect_width = SIZE_W'($urandom_range(0, 10));
      req.rect_height = SIZE_W'($urandom_range(0, 10));
    end
    if (req.command == roog_pkg::CMD_ADD) begin
      recent_adds = {recent_adds, req};
      if (recent_adds.size() > 8) void'(recent_adds.pop_front());
    end
    return req;
  endfunction

  task automatic send_request(input roog_pkg::in_t req);
    roog_pkg::out_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    predicted = apply_rectangle(req);
    pending_outcomes = {pending_outcomes, predicted};
    requests_sent++;
    if (req.command == roog_pkg::CMD_CHECK) checks_sent++;
  endtask

  task automatic send_rect(input logic [CMD_W-1:0] cmd, input logic [OWNER_W-1:0] id,
                           input int left, input int top, input int wid, input int hgt);
    roog_pkg::in_t req;
    req.command = cmd;
    req.owner_id = id;
    req.left_edge = EDGE_W'(left);
    req.top_edge = EDGE_W'(top);
    req.rect_width = SIZE_W'(wid);
    req.rect_height = SIZE_W'(hgt);
    send_request(req);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_request(make_random_request());
  endtask

  task automatic wait_for_outcomes();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_rect(roog_pkg::CMD_CHECK, 16'd5, 0, 0, 3, 3);
    send_rect(roog_pkg::CMD_CHECK, 16'd9, 17, 17, 0, 5);
    send_rect(roog_pkg::CMD_CHECK, 16'hFFFE, 17, 17, 5, 0);
    send_rect(roog_pkg::CMD_ADD, 16'd1, 0, 0, 4, 4);
    send_rect(roog_pkg::CMD_ADD, 16'd2, 2, 2, 4, 4);
    send_rect(roog_pkg::CMD_CHECK, 16'd1, 0, 0, 4, 4);
    send_rect(roog_pkg::CMD_CHECK, 16'd1, 0, 0, 2, 2);
    send_rect(roog_pkg::CMD_CHECK, 16'd2, 4, 4, 2, 2);
    send_rect(roog_pkg::CMD_ADD, 16'd0, 10, 10, 3, 3);
    send_rect(roog_pkg::CMD_CHECK, 16'd0, 10, 10, 3, 3);
    send_rect(roog_pkg::CMD_ADD, 16'd0, 0, 0, 1, 1);
    send_rect(roog_pkg::CMD_ADD, 16'hFFFF, 20, 20, 2, 2);
    send_rect(roog_pkg::CMD_CHECK, 16'hFFFF, 20, 20, 2, 2);
    send_rect(roog_pkg::CMD_ADD, 16'hFFFF, 20, 20, 3, 3);
    send_rect(roog_pkg::CMD_ADD, 16'h5555, 0, 100, 1024, 1);
    send_rect(roog_pkg::CMD_CHECK, 16'h5555, 0, 100, 1024, 1);
    send_rect(roog_pkg::CMD_ADD, 16'hAAAA, 1023, 0, 1, 1024);
    send_rect(roog_pkg::CMD_ADD, 16'd7, 1023, 1023, 1024, 1024);
    send_rect(roog_pkg::CMD_CHECK, 16'd0, 1000, 1010, 20, 100);
    send_rect(roog_pkg::CMD_CHECK, 16'd7, 1023, 1023, 2047, 2047);
    send_rect(roog_pkg::CMD_ADD, 16'd3, 1023, 500, 2047, 0);
    send_rect(roog_pkg::CMD_ADD, 16'd3, 600, 1023, 2047, 1);
    send_rect(roog_pkg::CMD_CHECK, 16'd0, 1023, 0, 0, 0);
    send_rect(roog_pkg::CMD_CHECK, 16'hAAAA, 1023, 0, 1, 100);
    wait_for_outcomes();
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 37;
    recv_idle_pct = 71;
    run_random(180);
  endtask

  task automatic test_receiver_gaps();
    send_idle_pct = 71;
    recv_idle_pct = 37;
    run_random(180);
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 5000;
    run_random(12);
    wait_for_outcomes();
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(90);
    wait_for_outcomes();
    run_random(90);
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(negedge clk) begin : check_outcome
    roog_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result: expected none, got intact %0d overlap %0d clipped %0d",
                 $time, out_data.intact, out_data.overlap_cells, out_data.clipped);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_data.intact !== want.intact) begin
          $display("%0t: intact mismatch: expected %0d, got %0d",
                   $time, want.intact, out_data.intact);
          mismatch_count++;
        end
        if (out_data.overlap_cells !== want.overlap_cells) begin
          $display("%0t: overlap_cells mismatch: expected %0d, got %0d",
                   $time, want.overlap_cells, out_data.overlap_cells);
          mismatch_count++;
        end
        if (out_data.clipped !== want.clipped) begin
          $display("%0t: clipped mismatch: expected %0d, got %0d",
                   $time, want.clipped, out_data.clipped);
          mismatch_count++;
        end
        if (out_data.intact === 1'b1) intact_seen++;
        if (out_data.clipped === 1'b1) clipped_seen++;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_sender_gaps();
    test_receiver_gaps();
    test_output_backpressure();
    test_full_rate();
    wait_for_outcomes();
    repeat (20) @(posedge clk);
    $display("Ran %0d requests (%0d checks, %0d found intact, %0d clipped) under mixed stalls,",
             requests_sent, checks_sent, intact_seen, clipped_seen);
    $display("ending with %0d overlapped cells and %0d mismatches.",
             overlap_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
